// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, switched off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check on clk, switched off while rst_n is low.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// File: rtl/spe_pkg.sv
// Types and constants shared by the sigmoid spectrum evaluator modules.
`default_nettype none
package spe_pkg;

  localparam int N_W        = 16;   // bits of the half-sigmoid offset
  localparam int ACC_W      = 100;  // width of the search accumulators
  localparam int D_W        = 63;   // width of 2^32 + |x|^2
  localparam int NUM_W      = 95;   // width of |x|^2 * 2^32
  localparam int SIG_W      = 17;
  localparam int GAIN_W     = 24;
  localparam int SRCH_STEPS = 16;

  localparam logic [SIG_W-1:0] SIG_HALF = 17'd32768;
  localparam logic [SIG_W-1:0] SIG_ONE  = 17'd65536;
  localparam logic [SIG_W-1:0] SIG_ZERO = 17'd0;

  // One classified request as it waits between front and back.
  typedef struct packed {
    logic              clamped;
    logic              neg;
    logic [GAIN_W-1:0] gain;
    logic [NUM_W-1:0]  num2;
    logic [D_W-1:0]    d;
  } work_t;

  // Request plus the running state of the bit-by-bit search.
  typedef struct packed {
    work_t            w;
    logic [N_W-1:0]   n;
    logic [ACC_W-1:0] p;
    logic [ACC_W-1:0] qd;
  } srch_t;

endpackage
`default_nettype wire

// File: rtl/spe_front.sv
// Front part: evaluates the quadratic exactly, clamps it and prepares the search terms.
`default_nettype none
module spe_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [13:0]               in_wavelength,
  input  wire logic signed [31:0]        in_coef_square,
  input  wire logic signed [31:0]        in_coef_linear,
  input  wire logic signed [31:0]        in_coef_const,
  input  wire logic [23:0]               in_gain,
  input  wire logic                      q_full,
  output logic                           push,
  output spe_pkg::work_t                 item
);

  logic en;

  // Stage 1: first products.
  logic               f1_vld_r;
  logic signed [46:0] f1_p1_r;
  logic [27:0]        f1_lsq_r;
  logic signed [31:0] f1_c0_r, f1_c2_r;
  logic [23:0]        f1_gain_r;

  // Stage 2: quadratic term.
  logic               f2_vld_r;
  logic signed [46:0] f2_p1_r;
  logic signed [60:0] f2_p0_r;
  logic signed [31:0] f2_c2_r;
  logic [23:0]        f2_gain_r;

  // Stage 3: exact sum, floor and clamp.
  logic               f3_vld_r;
  logic [31:0]        f3_ax_r;
  logic               f3_neg_r, f3_clamped_r;
  logic [23:0]        f3_gain_r;

  // Stage 4: square of |x|.
  logic               f4_vld_r;
  spe_pkg::work_t     f4_item_r;

  logic signed [69:0] s_sum;
  logic signed [37:0] x_val;
  logic [37:0]        x_abs;
  logic               x_hi, x_lo;
  logic [63:0]        sq;
  spe_pkg::work_t     item_nxt;

  assign en       = !(f4_vld_r && q_full);
  assign in_stall = !en;
  assign push     = f4_vld_r && !q_full;
  assign item     = f4_item_r;

  always_comb begin
    s_sum = (70'(f2_c2_r) <<< 32) + (70'(f2_p1_r) <<< 20) + 70'(f2_p0_r);
    x_val = $signed(s_sum[69:32]);
    x_hi  = x_val > 38'sd2147483647;
    x_lo  = x_val < -38'sd2147483648;
    x_abs = x_val[37] ? 38'(-x_val) : 38'(x_val);
  end

  always_comb begin
    sq               = f3_ax_r * f3_ax_r;
    item_nxt.clamped = f3_clamped_r;
    item_nxt.neg     = f3_neg_r;
    item_nxt.gain    = f3_gain_r;
    item_nxt.d       = sq[62:0] + 63'h1_0000_0000;
    item_nxt.num2    = {sq[62:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_p1_r      <= in_coef_linear * $signed({1'b0, in_wavelength});
      f1_lsq_r     <= in_wavelength * in_wavelength;
      f1_c0_r      <= in_coef_square;
      f1_c2_r      <= in_coef_const;
      f1_gain_r    <= in_gain;
      f2_p1_r      <= f1_p1_r;
      f2_p0_r      <= f1_c0_r * $signed({1'b0, f1_lsq_r});
      f2_c2_r      <= f1_c2_r;
      f2_gain_r    <= f1_gain_r;
      f3_ax_r      <= x_abs[31:0];
      f3_neg_r     <= x_val[37];
      f3_clamped_r <= x_hi || x_lo;
      f3_gain_r    <= f2_gain_r;
      f4_item_r    <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/spe_queue.sv
// Short request queue between the front and back parts.
`default_nettype none
module spe_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire spe_pkg::work_t               item_i,
  input  wire logic                         pop,
  output spe_pkg::work_t                    item_o,
  output logic                              empty,
  output logic                              full,
  output logic [$clog2(DEPTH+1)-1:0]        cnt
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  spe_pkg::work_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign empty  = cnt_r == '0;
  assign full   = cnt_r == CNT_FULL;
  assign cnt    = cnt_r;
  assign item_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/spe_step.sv
// One stage of the sigmoid search: decides a single bit of the offset.
`default_nettype none
module spe_step #(
  parameter int BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire spe_pkg::srch_t s_i,
  output logic                vld_o,
  output spe_pkg::srch_t      s_o
);

  logic                              vld_r;
  spe_pkg::srch_t                    s_r;
  logic signed [spe_pkg::ACC_W-1:0]  d_ext, pc, num_ext;
  logic                              ok;
  spe_pkg::srch_t                    s_nxt;

  // The candidate offset n + 2^BIT moves q = 2n-1 up by 2^(BIT+1), so
  // q^2*d grows by 2^(BIT+2)*q*d + 2^(2*BIT+2)*d.
  always_comb begin
    d_ext   = $signed(spe_pkg::ACC_W'(s_i.w.d));
    num_ext = $signed(spe_pkg::ACC_W'(s_i.w.num2));
    pc      = $signed(s_i.p) + ($signed(s_i.qd) <<< (BIT + 2)) + (d_ext <<< (2 * BIT + 2));
    ok      = !s_i.n[spe_pkg::N_W-1] && (s_i.w.neg ? (pc < num_ext) : (pc <= num_ext));
    s_nxt   = s_i;
    if (ok) begin
      s_nxt.n  = s_i.n | (spe_pkg::N_W'(1) << BIT);
      s_nxt.p  = pc;
      s_nxt.qd = $signed(s_i.qd) + (d_ext <<< (BIT + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign vld_o = vld_r;
  assign s_o   = s_r;

endmodule
`default_nettype wire

// File: rtl/spe_back.sv
// Back part: sixteen-stage sigmoid search, then the gain product and output register.
`default_nettype none
module spe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_vld,
  input  wire spe_pkg::work_t q_item,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [16:0]         out_sigmoid_value,
  output logic [23:0]         out_scaled_value,
  output logic                out_clamped
);

  localparam int STEPS = spe_pkg::SRCH_STEPS;

  logic           en;
  logic           vld   [STEPS+1];
  spe_pkg::srch_t st    [STEPS+1];

  logic                        out_valid_r, out_clamped_r;
  logic [spe_pkg::SIG_W-1:0]   out_sig_r, sig;
  logic [23:0]                 out_scaled_r;
  logic [40:0]                 prod;
  spe_pkg::srch_t              last;

  assign en  = !(out_valid_r && out_stall);
  assign pop = q_vld && en;

  // Start the search at n = 0, where q = -1: q^2*d = d and q*d = -d.
  always_comb begin
    vld[0]     = q_vld;
    st[0].w    = q_item;
    st[0].n    = '0;
    st[0].p    = spe_pkg::ACC_W'(q_item.d);
    st[0].qd   = -spe_pkg::ACC_W'(q_item.d);
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    spe_step #(.BIT(STEPS - 1 - k)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld[k]),
      .s_i   (st[k]),
      .vld_o (vld[k+1]),
      .s_o   (st[k+1])
    );
  end

  always_comb begin
    last = st[STEPS];
    if (last.w.clamped) begin
      sig = last.w.neg ? spe_pkg::SIG_ZERO : spe_pkg::SIG_ONE;
    end else if (last.w.neg) begin
      sig = spe_pkg::SIG_HALF - spe_pkg::SIG_W'(last.n);
    end else begin
      sig = spe_pkg::SIG_HALF + spe_pkg::SIG_W'(last.n);
    end
    prod = 41'(last.w.gain) * 41'(sig) + 41'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sig_r     <= sig;
      out_scaled_r  <= prod[39:16];
      out_clamped_r <= last.w.clamped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sigmoid_value = out_sig_r;
  assign out_scaled_value  = out_scaled_r;
  assign out_clamped       = out_clamped_r;

endmodule
`default_nettype wire

// File: rtl/sigmoid_polynomial_spectrum_eval.sv
// Top level of the sigmoid-polynomial spectrum sample evaluator.
//
// Usage: each request on the in_ channel carries a wavelength, three signed
// quadratic coefficients and a gain. The block returns one result per request
// on the out_ channel, in order: the sigmoid of the polynomial in Q1.16, the
// gain-scaled value in Q8.16 and a flag that marks a saturated polynomial.
// A request is taken at a rising edge with valid high and stall low.
// The block sustains one request per cycle while the output is not
// stalled. From acceptance to a valid result a request passes four front
// stages (two multiplier levels, the exact sum, the square of |x|), the
// queue, sixteen search stages that each settle one bit of the sigmoid
// offset with a wide add and compare, and the gain product register.
// When the receiver stalls, the back part holds its results and the queue
// fills; the front keeps accepting until the queue is full and its last
// stage holds a request, then raises in_stall. Reset empties the pipeline
// and the queue; no result is pending after reset, with no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module sigmoid_polynomial_spectrum_eval #(
  parameter int QDEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [13:0]        in_wavelength,
  input  wire logic signed [31:0] in_coef_square,
  input  wire logic signed [31:0] in_coef_linear,
  input  wire logic signed [31:0] in_coef_const,
  input  wire logic [23:0]        in_gain,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             out_sigmoid_value,
  output logic [23:0]             out_scaled_value,
  output logic                    out_clamped
);

  localparam int CNT_W = $clog2(QDEPTH + 1);

  // Front-to-queue and queue-to-back hookup.
  logic                push, pop, q_empty, q_full;
  spe_pkg::work_t      f_item, q_item;
  logic [CNT_W-1:0]    q_cnt;

  spe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_wavelength  (in_wavelength),
    .in_coef_square (in_coef_square),
    .in_coef_linear (in_coef_linear),
    .in_coef_const  (in_coef_const),
    .in_gain        (in_gain),
    .q_full         (q_full),
    .push           (push),
    .item           (f_item)
  );

  // The queue lets the front keep taking requests while the output waits.
  spe_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .item_i (f_item),
    .pop    (pop),
    .item_o (q_item),
    .empty  (q_empty),
    .full   (q_full),
    .cnt    (q_cnt)
  );

  spe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (!q_empty),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sigmoid_value (out_sigmoid_value),
    .out_scaled_value  (out_scaled_value),
    .out_clamped       (out_clamped)
  );

  // A saturated polynomial always yields a sigmoid of exactly zero or one.
  `ASSERT_IMPL(a_clamp_sig, out_valid && out_clamped, out_sigmoid_value == 17'd0 || out_sigmoid_value == 17'd65536, "clamped result with fractional sigmoid")
  // The queue never holds more requests than it has entries.
  `ASSERT_CLK(a_q_bound, q_cnt <= CNT_W'(QDEPTH), "queue overflow")
  // The queue fill moves by at most one request per cycle.
  `ASSERT_CLK(a_q_step, q_cnt == $past(q_cnt) || q_cnt == $past(q_cnt) + 1'b1 || q_cnt + 1'b1 == $past(q_cnt), "queue count jumped")

endmodule
`default_nettype wire

// File: test/spectrum_sample_checker.sv
// Checker that predicts and compares the spectrum sample results.
`timescale 1ns / 100ps
module spectrum_sample_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [13:0]        in_wavelength,
  input  wire logic signed [31:0] in_coef_square,
  input  wire logic signed [31:0] in_coef_linear,
  input  wire logic signed [31:0] in_coef_const,
  input  wire logic [23:0]        in_gain,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [16:0]        out_sigmoid_value,
  input  wire logic [23:0]        out_scaled_value,
  input  wire logic               out_clamped,
  output int                      fail_count,
  output int                      requests_taken,
  output int                      results_seen
);

  typedef struct {
    logic [16:0] sigmoid;
    logic [23:0] scaled;
    logic        clamped;
  } sample_t;

  sample_t expected_samples[$];

  // Exact polynomial, floor to Q16.16, clamp, then a rounded sigmoid found by
  // binary search with integer comparisons only.
  function automatic sample_t sigmoid_sample(logic [13:0] wl, logic signed [31:0] cq,
                                             logic signed [31:0] cl, logic signed [31:0] cc,
                                             logic [23:0] gain);
    logic signed [127:0] s0, s1, s2, ll, acc, xs;
    logic [127:0] ax, den, num2, q;
    logic [47:0] prod;
    int lo, hi, mid;
    sample_t r;
    s0 = cq;
    s1 = cl;
    s2 = cc;
    ll = {114'd0, wl};
    acc = (s2 <<< 32) + ((s1 * ll) <<< 20) + s0 * ll * ll;
    xs = acc >>> 32;
    r.clamped = 1'b0;
    if (xs > 128'sd2147483647) begin
      r.clamped = 1'b1;
      r.sigmoid = 17'd65536;
    end else if (xs < -128'sd2147483648) begin
      r.clamped = 1'b1;
      r.sigmoid = 17'd0;
    end else begin
      ax = (xs < 0) ? -xs : xs;
      den = (128'd1 << 32) + ax * ax;
      num2 = (ax * ax) << 32;
      lo = 0;
      hi = 32768;
      if (xs >= 0) begin
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          q = 2 * mid - 1;
          if (q * q * den <= num2) lo = mid;
          else hi = mid - 1;
        end
        r.sigmoid = 17'(32768 + lo);
      end else begin
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          q = 2 * mid + 1;
          if (num2 <= q * q * den) hi = mid;
          else lo = mid + 1;
        end
        r.sigmoid = 17'(32768 - lo);
      end
    end
    prod = 48'(gain) * 48'(r.sigmoid) + 48'd32768;
    r.scaled = prod[39:16];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    requests_taken = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && in_valid && !in_stall) begin
      expected_samples.push_back(sigmoid_sample(in_wavelength, in_coef_square,
                                                in_coef_linear, in_coef_const, in_gain));
      requests_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result, sigmoid", out_sigmoid_value, -1);
      end else begin
        want = expected_samples.pop_front();
        if (out_sigmoid_value !== want.sigmoid)
          report_mismatch("sigmoid_value", out_sigmoid_value, want.sigmoid);
        if (out_scaled_value !== want.scaled)
          report_mismatch("scaled_value", out_scaled_value, want.scaled);
        if (out_clamped !== want.clamped)
          report_mismatch("clamped", out_clamped, want.clamped);
      end
      results_seen++;
    end
  end

endmodule

// File: test/sigmoid_polynomial_spectrum_eval_tb.sv
// Testbench top: stimulus, stalls and the verdict for the spectrum evaluator.
`timescale 1ns / 100ps
module sigmoid_polynomial_spectrum_eval_tb;

  // The run is bounded by this many cycles; a correct run needs far fewer.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 1000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [13:0]        in_wavelength = '0;
  logic signed [31:0] in_coef_square = '0;
  logic signed [31:0] in_coef_linear = '0;
  logic signed [31:0] in_coef_const = '0;
  logic [23:0]        in_gain = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [16:0]        out_sigmoid_value;
  logic [23:0]        out_scaled_value;
  logic               out_clamped;

  int fail_count;
  int requests_taken;
  int results_seen;
  int cycle_count = 0;
  // While calm is set, neither side idles.
  logic calm = 1'b0;

  always #1 clk = ~clk;

  sigmoid_polynomial_spectrum_eval dut (.*);

  spectrum_sample_checker checker_i (.*);

  // While calm is clear, the receiver stalls at random in about a quarter of the cycles.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 26);
  end

  // A hung pipeline ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Each cycle
  // before it may be idle with the same chance, so the sender idles in about
  // a quarter of its cycles; valid is only lowered in such an idle cycle, so
  // back-to-back requests keep valid high with a single assignment per edge.
  task automatic send_request(logic [13:0] wl, logic [31:0] cq, logic [31:0] cl,
                              logic [31:0] cc, logic [23:0] gain);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_wavelength  <= wl;
    in_coef_square <= cq;
    in_coef_linear <= cl;
    in_coef_const  <= cc;
    in_gain        <= gain;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop sending and wait for every outstanding request to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (requests_taken != results_seen);
    @(posedge clk);
  endtask

  // A random coefficient: full range, or shifted down so that the polynomial
  // mostly stays in range and the sigmoid search is exercised.
  function automatic logic [31:0] pick_coef(int narrow_from);
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) v = v >>> $urandom_range(31, narrow_from);
    return v;
  endfunction

  initial begin
    logic [13:0] wl;
    logic [23:0] gain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: zero polynomial, both range limits, the saturated
    // polynomial on both sides, and the gain and wavelength extremes.
    send_request(14'd0,     32'd0,          32'd0,          32'd0,          24'd65536);
    send_request(14'd16383, 32'd0,          32'd0,          32'd0,          24'hFFFFFF);
    send_request(14'd0,     32'd0,          32'd0,          32'h7FFFFFFF,   24'hFFFFFF);
    send_request(14'd0,     32'd0,          32'd0,          32'h80000000,   24'hFFFFFF);
    send_request(14'd16383, 32'h7FFFFFFF,   32'h7FFFFFFF,   32'h7FFFFFFF,   24'hFFFFFF);
    send_request(14'd16383, 32'h80000000,   32'h80000000,   32'h80000000,   24'hFFFFFF);
    send_request(14'd16383, 32'h7FFFFFFF,   32'h80000000,   32'd0,          24'd0);
    send_request(14'd1,     32'd0,          32'd4096,       32'h7FFFFFFF,   24'd65536);
    send_request(14'd1,     32'd0,          32'hFFFFF000,   32'h80000000,   24'd65536);
    send_request(14'd6400,  32'd1,          32'hFFFFFFFF,   32'd1,          24'd65536);
    send_request(14'd0,     32'hFFFFFFFF,   32'd0,          32'hFFFFFFFF,   24'd1);
    send_request(14'd0,     32'd0,          32'd0,          32'd65536,      24'd65536);
    send_request(14'd0,     32'd0,          32'd0,          32'hFFFF0000,   24'd65536);
    send_request(14'd8000,  32'h00001000,   32'hFFF00000,   32'd12345,      24'd98304);
    send_request(14'd16383, 32'hFFFFFFFF,   32'h7FFFFFFF,   32'h80000000,   24'h800000);

    // Let the pipeline empty completely before the random part.
    drain_results();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == 700) drain_results();
      wl = ($urandom_range(3) == 0) ? 14'($urandom_range(16383))
                                    : 14'($urandom_range(12000, 4800));
      case ($urandom_range(3))
        0: gain = 24'd65536;
        1: gain = 24'($urandom_range(16777215));
        2: gain = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
        default: gain = 24'($urandom_range(131072));
      endcase
      send_request(wl, pick_coef(12), pick_coef(8), pick_coef(0), gain);
    end
    calm = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && requests_taken == results_seen) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/spe_pkg.sv
rtl/spe_front.sv
rtl/spe_queue.sv
rtl/spe_step.sv
rtl/spe_back.sv
rtl/sigmoid_polynomial_spectrum_eval.sv
test/spectrum_sample_checker.sv
test/sigmoid_polynomial_spectrum_eval_tb.sv
